// ----- rtl/core/stid_pkg.sv -----
// Shared types and constants for the sliding template island detector.
`default_nettype none

package stid_pkg;

    localparam int TEMPLATE_BYTES = 25;
    localparam int WORD_COUNT     = 6;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 32;
    localparam int FILL_W         = 5;
    localparam int CNT_W          = 4;   // transitions inside one byte, 0..8
    localparam int GRP_W          = 6;   // one group of five bytes, 0..40
    localparam int GRP_BYTES      = 5;
    localparam int ISL_W          = 8;   // islands over the window, 0..200

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WORD0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WORD5 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 3'd7;

    // Reset values of the template and the limit
    localparam logic [CFG_DATA_W-1:0] WORD_RESET [WORD_COUNT] = '{
        32'd3547562033, 32'd2209026197, 32'd1044942905,
        32'd3711645219, 32'd1781133488, 32'd3338189312
    };
    localparam logic [7:0] TAIL_RESET  = 8'd185;
    localparam logic [7:0] LIMIT_RESET = 8'd60;

    typedef logic [7:0] byte_t;
    typedef logic [TEMPLATE_BYTES-1:0][7:0] tmpl_t;

    typedef struct packed {
        logic valid;
        logic full;
    } stage_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/core/stid_cfg_regs.sv -----
// Template and island limit configuration registers.
`default_nettype none

module stid_cfg_regs
    import stid_pkg::*;
(
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   cfg_we,
    input  wire [CFG_IDX_W-1:0]   cfg_index,
    input  wire [CFG_DATA_W-1:0]  cfg_data,
    output tmpl_t                 tmpl,
    output logic [7:0]            limit
);

    logic [CFG_DATA_W-1:0] word_reg  [WORD_COUNT];
    logic [CFG_DATA_W-1:0] word_next [WORD_COUNT];
    logic [7:0]            tail_reg, tail_next;
    logic [7:0]            limit_reg, limit_next;

    always_comb
    begin
        word_next  = word_reg;
        tail_next  = tail_reg;
        limit_next = limit_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TAIL:  tail_next  = cfg_data[7:0];
                CFG_LIMIT: limit_next = cfg_data[7:0];
                default:   word_next[cfg_index] = cfg_data;  // CFG_WORD0 .. CFG_WORD5
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg  <= WORD_RESET;
            tail_reg  <= TAIL_RESET;
            limit_reg <= LIMIT_RESET;
        end
        else
        begin
            word_reg  <= word_next;
            tail_reg  <= tail_next;
            limit_reg <= limit_next;
        end
    end

    // Lower-numbered byte sits in the upper bits of its word.
    for (genvar k = 0; k < WORD_COUNT * 4; k++)
    begin : g_tbyte
        assign tmpl[k] = word_reg[k / 4][CFG_DATA_W-1-8*(k % 4) -: 8];
    end
    assign tmpl[TEMPLATE_BYTES-1] = tail_reg;

    assign limit = limit_reg;

endmodule

`default_nettype wire

// ----- rtl/core/stid_match_stage.sv -----
// Byte window shift line, fill counter and per-byte transition counts.
`default_nettype none

module stid_match_stage
    import stid_pkg::*;
#(
    parameter int WINDOW_BYTES = 25
)
(
    input  wire               clk,
    input  wire               rst_n,
    input  wire               in_valid,
    output logic              in_stall,
    input  wire [7:0]         data_byte,
    input  tmpl_t             tmpl,
    input  wire               down_ready,
    output stage_ctl_t        ctl,
    output logic [CNT_W-1:0]  cnt [WINDOW_BYTES]
);

    localparam int HIST = WINDOW_BYTES - 1;

    logic             accept;
    logic             full_now;
    byte_t            cur_bytes [WINDOW_BYTES];
    logic [CNT_W-1:0] cnt_next  [WINDOW_BYTES];
    logic [CNT_W-1:0] cnt_reg   [WINDOW_BYTES];
    logic             valid_reg, valid_next;
    logic             full_reg;

    assign in_stall = valid_reg && !down_ready;
    assign accept   = in_valid && !in_stall;

    if (HIST > 0)
    begin : g_hist
        byte_t             win_reg  [HIST];
        byte_t             win_next [HIST];
        logic [FILL_W-1:0] fill_reg, fill_next;

        assign full_now = (fill_reg == FILL_W'(HIST));

        // New byte enters at the young end; older bytes move toward index 0.
        always_comb
        begin
            win_next  = win_reg;
            fill_next = fill_reg;
            if (accept)
            begin
                for (int i = 0; i < HIST - 1; i++)
                begin
                    win_next[i] = win_reg[i+1];
                end
                win_next[HIST-1] = data_byte;
                if (!full_now)
                begin
                    fill_next = fill_reg + 1'b1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                win_reg  <= '{default: '0};
                fill_reg <= '0;
            end
            else
            begin
                win_reg  <= win_next;
                fill_reg <= fill_next;
            end
        end

        for (genvar i = 0; i < HIST; i++)
        begin : g_cur
            assign cur_bytes[i] = win_reg[i];
        end
        assign cur_bytes[HIST] = data_byte;
    end
    else
    begin : g_nohist
        assign full_now     = 1'b1;
        assign cur_bytes[0] = data_byte;
    end

    // Mismatch transitions inside each byte, with the last bit of the byte
    // before (or an implied match ahead of byte 0) as the starting point.
    always_comb
    begin
        byte_t            diff;
        byte_t            trans;
        logic             prev;
        logic [CNT_W-1:0] c;
        prev = 1'b0;
        for (int i = 0; i < WINDOW_BYTES; i++)
        begin
            diff  = cur_bytes[i] ^ tmpl[i];
            trans = diff ^ {prev, diff[7:1]};
            prev  = diff[0];
            c = '0;
            for (int b = 0; b < 8; b++)
            begin
                c = c + CNT_W'(trans[b]);
            end
            cnt_next[i] = c;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (down_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            full_reg <= full_now;
            cnt_reg  <= cnt_next;
        end
    end

    assign ctl.valid = valid_reg;
    assign ctl.full  = full_reg;
    assign cnt       = cnt_reg;

endmodule

`default_nettype wire

// ----- rtl/core/stid_group_sum.sv -----
// Partial island sums over groups of five bytes.
`default_nettype none

module stid_group_sum
    import stid_pkg::*;
#(
    parameter int WINDOW_BYTES = 25
)
(
    input  wire               clk,
    input  wire               rst_n,
    input  stage_ctl_t        up_ctl,
    input  wire [CNT_W-1:0]   cnt [WINDOW_BYTES],
    output logic              up_ready,
    input  wire               down_ready,
    output stage_ctl_t        ctl,
    output logic [GRP_W-1:0]  grp [(WINDOW_BYTES + GRP_BYTES - 1) / GRP_BYTES]
);

    localparam int GROUPS = (WINDOW_BYTES + GRP_BYTES - 1) / GRP_BYTES;

    logic             load;
    logic             valid_reg, valid_next;
    logic             full_reg;
    logic [GRP_W-1:0] grp_next [GROUPS];
    logic [GRP_W-1:0] grp_reg  [GROUPS];

    assign up_ready = !valid_reg || down_ready;
    assign load     = up_ctl.valid && up_ready;

    always_comb
    begin
        logic [GRP_W-1:0] s;
        for (int g = 0; g < GROUPS; g++)
        begin
            s = '0;
            for (int j = 0; j < GRP_BYTES; j++)
            begin
                if (g * GRP_BYTES + j < WINDOW_BYTES)
                begin
                    s = s + GRP_W'(cnt[g * GRP_BYTES + j]);
                end
            end
            grp_next[g] = s;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (down_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            full_reg <= up_ctl.full;
            grp_reg  <= grp_next;
        end
    end

    assign ctl.valid = valid_reg;
    assign ctl.full  = full_reg;
    assign grp       = grp_reg;

endmodule

`default_nettype wire

// ----- rtl/core/stid_score_stage.sv -----
// Final island count, limit compare and result register.
`default_nettype none

module stid_score_stage
    import stid_pkg::*;
#(
    parameter int WINDOW_BYTES = 25
)
(
    input  wire               clk,
    input  wire               rst_n,
    input  stage_ctl_t        up_ctl,
    input  wire [GRP_W-1:0]   grp [(WINDOW_BYTES + GRP_BYTES - 1) / GRP_BYTES],
    input  wire [7:0]         limit,
    output logic              up_ready,
    output logic              out_valid,
    input  wire               out_stall,
    output logic              window_full,
    output logic [ISL_W-1:0]  island_count,
    output logic              detected
);

    localparam int GROUPS = (WINDOW_BYTES + GRP_BYTES - 1) / GRP_BYTES;

    logic             load;
    logic [ISL_W-1:0] total;
    logic             valid_reg, valid_next;
    logic             full_reg;
    logic [ISL_W-1:0] count_reg;
    logic             det_reg;

    assign up_ready = !valid_reg || !out_stall;
    assign load     = up_ctl.valid && up_ready;

    always_comb
    begin
        total = '0;
        for (int g = 0; g < GROUPS; g++)
        begin
            total = total + ISL_W'(grp[g]);
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Results before the window is full report all zero.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            full_reg  <= up_ctl.full;
            count_reg <= up_ctl.full ? total : '0;
            det_reg   <= up_ctl.full && (total < limit);
        end
    end

    assign out_valid    = valid_reg;
    assign window_full  = full_reg;
    assign island_count = count_reg;
    assign detected     = det_reg;

endmodule

`default_nettype wire

// ----- rtl/core/sliding_template_island_detector_core.sv -----
// Result path: an accepted byte is registered in the match, group sum and score
//   registers in turn before out_valid rises.
// Throughput: one byte per cycle; a new transfer is taken every cycle the output
//   is not stalled, set by the three-register pipeline with per-stage valid bits.
// Reset (rst_n low, async): pipeline empty, window zero, fill count zero,
//   template and island limit back to their default values.
// Top level of the sliding template island detector.
`default_nettype none

module sliding_template_island_detector_core
    import stid_pkg::*;
#(
    parameter int WINDOW_BYTES = 25
)
(
    input  wire                   clk,
    input  wire                   rst_n,

    // Input channel: one demodulated byte per transfer
    input  wire                   in_valid,
    output logic                  in_stall,
    input  wire [7:0]             data_byte,

    // Output channel: one result per input transfer
    output logic                  out_valid,
    input  wire                   out_stall,
    output logic                  window_full,
    output logic [ISL_W-1:0]      island_count,
    output logic                  detected,

    // Configuration write port
    input  wire                   cfg_we,
    input  wire [CFG_IDX_W-1:0]   cfg_index,
    input  wire [CFG_DATA_W-1:0]  cfg_data
);

    localparam int GROUPS = (WINDOW_BYTES + GRP_BYTES - 1) / GRP_BYTES;

    tmpl_t            tmpl;
    logic [7:0]       limit;

    stage_ctl_t       s1_ctl;
    stage_ctl_t       s2_ctl;
    logic             s2_ready;
    logic             s3_ready;
    logic [CNT_W-1:0] s1_cnt [WINDOW_BYTES];
    logic [GRP_W-1:0] s2_grp [GROUPS];

    // Template bytes and island limit; to be written only while the pipeline is idle (not enforced here).
    stid_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .tmpl      (tmpl),
        .limit     (limit)
    );

    // Stage 1: the window shifts on each transfer; the byte just taken plus
    // the held history is compared with the template and each byte's
    // match/mismatch transitions are counted.
    stid_match_stage #(
        .WINDOW_BYTES (WINDOW_BYTES)
    ) u_match
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .tmpl       (tmpl),
        .down_ready (s2_ready),
        .ctl        (s1_ctl),
        .cnt        (s1_cnt)
    );

    // Stage 2: per-byte counts folded into groups of five.
    stid_group_sum #(
        .WINDOW_BYTES (WINDOW_BYTES)
    ) u_group
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_ctl     (s1_ctl),
        .cnt        (s1_cnt),
        .up_ready   (s2_ready),
        .down_ready (s3_ready),
        .ctl        (s2_ctl),
        .grp        (s2_grp)
    );

    // Stage 3: total island count, limit compare, output register.
    stid_score_stage #(
        .WINDOW_BYTES (WINDOW_BYTES)
    ) u_score
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .up_ctl       (s2_ctl),
        .grp          (s2_grp),
        .limit        (limit),
        .up_ready     (s3_ready),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .window_full  (window_full),
        .island_count (island_count),
        .detected     (detected)
    );

endmodule

`default_nettype wire
